@@ src/mrlc_pkg.sv @@
// Shared types, constants and keyword tables for the modem reply line classifier.
`default_nettype none
package mrlc_pkg;

  localparam int unsigned LINE_CAPACITY = 128;
  localparam int unsigned CNT_W = $clog2(LINE_CAPACITY);
  localparam int unsigned LEN_W = 7;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_CAPACITY - 1);

  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_L    = 8'h4C;

  localparam logic [2:0] ERR_DONE = 3'd4;
  localparam logic [1:0] FAIL_DONE = 2'd3;

  localparam logic VERDICT_OK  = 1'b0;
  localparam logic VERDICT_BAD = 1'b1;

  typedef struct packed {
    logic             valid;
    logic             verdict;
    logic [LEN_W-1:0] length;
  } mrlc_res_t;

  function automatic logic [7:0] err_char(input logic [2:0] p);
    logic [7:0] ch;
    unique case (p)
      3'd0:    ch = CH_E;
      3'd1:    ch = CH_R;
      3'd2:    ch = CH_R;
      3'd3:    ch = CH_O;
      default: ch = CH_R;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] fail_char(input logic [1:0] p);
    logic [7:0] ch;
    unique case (p)
      2'd0:    ch = CH_F;
      2'd1:    ch = CH_A;
      2'd2:    ch = CH_I;
      default: ch = CH_L;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

@@ src/mrlc_match.sv @@
// Line state and keyword matchers; produces at most one result per accepted byte.
`default_nettype none
module mrlc_match
  import mrlc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output mrlc_res_t       res
);

  logic [CNT_W-1:0] line_count_r, line_count_nxt;
  logic             ok_progress_r, ok_progress_nxt;
  logic [2:0]       error_progress_r, error_progress_nxt;
  logic [1:0]       fail_progress_r, fail_progress_nxt;
  logic             ok_found_r, ok_found_nxt;
  logic             bad_found_r, bad_found_nxt;
  logic             zero_seen_r, zero_seen_nxt;

  logic             do_match;
  logic [CNT_W-1:0] cnt_inc;
  logic [2:0]       ep;
  logic             ok_hit, err_hit, fail_hit;
  logic             okf, badf;
  logic [2:0]       ep_adv;
  logic [1:0]       fp_adv;

  always_comb begin
    cnt_inc  = line_count_r + CNT_W'(1);
    do_match = (rx_byte != CH_NUL) && !zero_seen_r;
    ep       = (error_progress_r > ERR_DONE) ? 3'd0 : error_progress_r;

    ok_hit   = ok_progress_r && (rx_byte == CH_K);
    err_hit  = (rx_byte == err_char(ep)) && (ep == ERR_DONE);
    fail_hit = (rx_byte == fail_char(fail_progress_r)) && (fail_progress_r == FAIL_DONE);

    if (rx_byte == err_char(ep)) begin
      ep_adv = (ep == ERR_DONE) ? 3'd0 : ep + 3'd1;
    end else begin
      ep_adv = (rx_byte == CH_E) ? 3'd1 : 3'd0;
    end
    if (rx_byte == fail_char(fail_progress_r)) begin
      fp_adv = (fail_progress_r == FAIL_DONE) ? 2'd0 : fail_progress_r + 2'd1;
    end else begin
      fp_adv = (rx_byte == CH_F) ? 2'd1 : 2'd0;
    end

    okf  = ok_found_r || (do_match && ok_hit);
    badf = bad_found_r || (do_match && (err_hit || fail_hit));

    line_count_nxt     = line_count_r;
    ok_progress_nxt    = ok_progress_r;
    error_progress_nxt = error_progress_r;
    fail_progress_nxt  = fail_progress_r;
    ok_found_nxt       = ok_found_r;
    bad_found_nxt      = bad_found_r;
    zero_seen_nxt      = zero_seen_r;

    res.valid   = 1'b0;
    res.verdict = okf ? VERDICT_OK : VERDICT_BAD;
    res.length  = LEN_W'(cnt_inc);

    if (accept) begin
      if (line_count_r >= CNT_LAST || rx_byte == CH_LF) begin
        res.valid          = (line_count_r < CNT_LAST) && (okf || badf);
        line_count_nxt     = '0;
        ok_progress_nxt    = 1'b0;
        error_progress_nxt = 3'd0;
        fail_progress_nxt  = 2'd0;
        ok_found_nxt       = 1'b0;
        bad_found_nxt      = 1'b0;
        zero_seen_nxt      = 1'b0;
      end else begin
        line_count_nxt = cnt_inc;
        zero_seen_nxt  = zero_seen_r || (rx_byte == CH_NUL);
        ok_found_nxt   = okf;
        bad_found_nxt  = badf;
        if (do_match) begin
          ok_progress_nxt    = (rx_byte == CH_O);
          error_progress_nxt = ep_adv;
          fail_progress_nxt  = fp_adv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r     <= '0;
      ok_progress_r    <= 1'b0;
      error_progress_r <= 3'd0;
      fail_progress_r  <= 2'd0;
      ok_found_r       <= 1'b0;
      bad_found_r      <= 1'b0;
      zero_seen_r      <= 1'b0;
    end else begin
      line_count_r     <= line_count_nxt;
      ok_progress_r    <= ok_progress_nxt;
      error_progress_r <= error_progress_nxt;
      fail_progress_r  <= fail_progress_nxt;
      ok_found_r       <= ok_found_nxt;
      bad_found_r      <= bad_found_nxt;
      zero_seen_r      <= zero_seen_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/mrlc_out_reg.sv @@
// Result register that holds one verdict until the consumer takes it.
`default_nettype none
module mrlc_out_reg
  import mrlc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mrlc_res_t        res,
  output logic                  can_take,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_verdict,
  output logic [LEN_W-1:0]      out_line_length
);

  logic             valid_r, valid_nxt;
  logic             verdict_r;
  logic [LEN_W-1:0] length_r;

  assign can_take = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      verdict_r <= res.verdict;
      length_r  <= res.length;
    end
  end

  assign out_valid       = valid_r;
  assign out_verdict     = verdict_r;
  assign out_line_length = length_r;

endmodule
`default_nettype wire

@@ src/modem_reply_line_classifier.sv @@
// Top level of the modem reply line classifier.
//
//   Channel   Direction  Ports                               Carries
//   in_       input      in_valid, in_ready, in_rx_byte      one received byte
//   out_      output     out_valid, out_ready, out_verdict,  one line verdict
//                        out_line_length
//
// One byte is taken every cycle while in_ready is high; the matchers update in the cycle of acceptance.
// A verdict appears in the result register in the cycle after its newline is taken.
// The input stalls only while a verdict waits in the result register unread.
// Synchronous active-low reset clears the line state and the result register's valid flag.
`default_nettype none
module modem_reply_line_classifier
  import mrlc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_rx_byte,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_verdict,
  output logic [LEN_W-1:0]      out_line_length
);

  mrlc_res_t res;
  logic      accept;

  assign accept = in_valid && in_ready;

  mrlc_match u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .res     (res)
  );

  mrlc_out_reg u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res             (res),
    .can_take        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_verdict     (out_verdict),
    .out_line_length (out_line_length)
  );

  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("Input taken while a verdict waits unread.");

  a_result_from_newline: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (accept && in_rx_byte == CH_LF))
    else $error("Verdict produced without an accepted newline.");

  a_length_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> (out_valid && out_line_length != '0))
    else $error("Verdict registered with zero line length.");

endmodule
`default_nettype wire

@@ tb/sv/mrlc_line_checker.sv @@
// Checker for the modem reply line classifier: predicts line verdicts and compares them.
module mrlc_line_checker
  import mrlc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       in_rx_byte,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic             out_verdict,
  input  logic [LEN_W-1:0] out_line_length,
  output int               errors,
  output int               pending,
  output int               ok_lines,
  output int               bad_lines,
  output int               dropped_lines
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             verdict;
    logic [LEN_W-1:0] line_length;
  } line_verdict_t;

  localparam logic [39:0] ERROR_WORD = {CH_E, CH_R, CH_R, CH_O, CH_R};
  localparam logic [31:0] FAIL_WORD  = {CH_F, CH_A, CH_I, CH_L};

  logic [CNT_W-1:0] line_len;
  logic             ok_armed;
  logic [2:0]       err_pos;
  logic [1:0]       fail_pos;
  logic             ok_hit;
  logic             bad_hit;
  logic             nul_seen;
  line_verdict_t    line_verdicts_q[$];

  task automatic clear_line_state();
    line_len = '0;
    ok_armed = 1'b0;
    err_pos  = '0;
    fail_pos = '0;
    ok_hit   = 1'b0;
    bad_hit  = 1'b0;
    nul_seen = 1'b0;
  endtask

  task automatic scan_keywords(input logic [7:0] b);
    if (ok_armed && b == CH_K) begin
      ok_hit = 1'b1;
    end
    ok_armed = (b == CH_O);

    if (b == ERROR_WORD[8*(4-int'(err_pos)) +: 8]) begin
      if (err_pos == ERR_DONE) begin
        bad_hit = 1'b1;
        err_pos = '0;
      end else begin
        err_pos = err_pos + 3'd1;
      end
    end else begin
      err_pos = (b == CH_E) ? 3'd1 : 3'd0;
    end

    if (b == FAIL_WORD[8*(3-int'(fail_pos)) +: 8]) begin
      if (fail_pos == FAIL_DONE) begin
        bad_hit  = 1'b1;
        fail_pos = '0;
      end else begin
        fail_pos = fail_pos + 2'd1;
      end
    end else begin
      fail_pos = (b == CH_F) ? 2'd1 : 2'd0;
    end
  endtask

  task automatic classify_byte(input logic [7:0] b);
    line_verdict_t v;
    if (line_len == CNT_LAST) begin
      clear_line_state();
      dropped_lines++;
      return;
    end
    line_len = line_len + 1'b1;
    if (b == CH_NUL) begin
      nul_seen = 1'b1;
    end else if (!nul_seen) begin
      scan_keywords(b);
    end
    if (b == CH_LF) begin
      if (ok_hit || bad_hit) begin
        v.verdict     = ok_hit ? VERDICT_OK : VERDICT_BAD;
        v.line_length = LEN_W'(line_len);
        line_verdicts_q.push_back(v);
      end
      clear_line_state();
    end
  endtask

  always @(posedge clk) begin
    line_verdict_t want;
    if (!rst_n) begin
      clear_line_state();
      line_verdicts_q.delete();
      errors        = 0;
      ok_lines      = 0;
      bad_lines     = 0;
      dropped_lines = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (line_verdicts_q.size() == 0) begin
          $error("Unexpected verdict: verdict %0d, line_length %0d",
                 out_verdict, out_line_length);
          errors++;
        end else begin
          want = line_verdicts_q.pop_front();
          if (out_verdict !== want.verdict) begin
            $error("verdict: expected %0d, actual %0d", want.verdict, out_verdict);
            errors++;
          end
          if (out_line_length !== want.line_length) begin
            $error("line_length: expected %0d, actual %0d",
                   want.line_length, out_line_length);
            errors++;
          end
          if (want.verdict == VERDICT_OK) begin
            ok_lines++;
          end else begin
            bad_lines++;
          end
        end
      end
      if (in_valid && in_ready) begin
        classify_byte(in_rx_byte);
      end
    end
    pending = line_verdicts_q.size();
  end

endmodule

@@ tb/sv/tb_modem_reply_line_classifier.sv @@
// Testbench top for the modem reply line classifier: stimulus, reset and verdict.
module tb_modem_reply_line_classifier
  import mrlc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_rx_byte;
  logic             out_valid;
  logic             out_ready;
  logic             out_verdict;
  logic [LEN_W-1:0] out_line_length;

  int   errors;
  int   pending;
  int   ok_lines;
  int   bad_lines;
  int   dropped_lines;
  int   bytes_sent = 0;
  bit   idle_on = 1'b1;
  int   stall_left = 0;
  logic [7:0] line_buf[$];

  always #1 clk = ~clk;

  modem_reply_line_classifier i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_verdict     (out_verdict),
    .out_line_length (out_line_length)
  );

  mrlc_line_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_verdict     (out_verdict),
    .out_line_length (out_line_length),
    .errors          (errors),
    .pending         (pending),
    .ok_lines        (ok_lines),
    .bad_lines       (bad_lines),
    .dropped_lines   (dropped_lines)
  );

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic flush_line();
    foreach (line_buf[i]) push_byte(line_buf[i]);
    line_buf.delete();
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic fill_to(input int n);
    while (line_buf.size() < n) line_buf.push_back(8'($urandom_range(97, 122)));
  endtask

  function automatic string pick_word();
    case ($urandom_range(0, 19))
      0:       return "OK";
      1:       return "ERROR";
      2:       return "FAIL";
      3:       return "ERRERROR";
      4:       return "FFAIL";
      5:       return "OOK";
      6:       return "EERROR";
      7:       return "ERRO";
      8:       return "FAI";
      9:       return "O";
      10:      return "K";
      11:      return "E";
      12:      return "F";
      13:      return "AT+CSQ";
      14:      return "ready";
      15:      return "\r";
      16:      return "FAERROR";
      17:      return "+IPD,4:";
      18:      return "R";
      default: return " ";
    endcase
  endfunction

  task automatic build_reply_line();
    int n;
    n = $urandom_range(0, 5);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0:       line_buf.push_back(8'($urandom_range(32, 126)));
        1:       line_buf.push_back(CH_NUL);
        default: add_text(pick_word());
      endcase
    end
    line_buf.push_back(CH_LF);
  endtask

  initial begin
    int kind;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    add_text("OK\n");
    add_text("ERROR\n");
    add_text("FAIL\n");
    add_text("OKFAIL\n");
    add_text("AT\n");
    line_buf.push_back(8'hFF);
    line_buf.push_back(CH_NUL);
    add_text("OK\n");
    flush_line();
    drain_results();

    add_text("OK");
    fill_to(126);
    line_buf.push_back(CH_LF);
    fill_to(254);
    line_buf.push_back(CH_LF);
    add_text("FAIL\n");
    fill_to(388);
    add_text("XERROR\n");
    flush_line();

    while (bytes_sent < 1050) begin
      idle_on = (bytes_sent < 950) && ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 99);
      if (kind < 70) begin
        build_reply_line();
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 24)) line_buf.push_back(8'($urandom()));
        if ($urandom_range(0, 1) == 0) begin
          line_buf.push_back(CH_LF);
        end
      end else if (kind < 96) begin
        repeat ($urandom_range(1, 3)) add_text(pick_word());
      end else begin
        add_text(pick_word());
        fill_to($urandom_range(100, 128));
        line_buf.push_back(CH_LF);
      end
      flush_line();
      if ($urandom_range(0, 49) == 0) begin
        drain_results();
      end
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Run covered %0d received bytes and %0d checked verdicts (%0d success, %0d failure).",
             bytes_sent, ok_lines + bad_lines, ok_lines, bad_lines);
    $display("Lines restarted on a full buffer: %0d; mismatches: %0d.", dropped_lines, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("Timeout: %0d verdicts still outstanding.", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
